>>> rtl/srt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the static route table
// Operation codes passed from the front classifier to the back end, result
// status codes, queue word layout and configuration register indexes.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int ADDR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int Q_DEPTH = 2;

  // input mode field
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_ROUTE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_GATEWAY   = 1'b0;
  localparam logic CFG_BROADCAST = 1'b1;

  typedef enum logic [2:0] {
    OP_INVALID = 3'd0,  // add with zero address or zero hop
    OP_ADD     = 3'd1,
    OP_DELIVER = 3'd2,  // upward packet for this hop or broadcast
    OP_LOOKUP  = 3'd3,  // packet needs a next hop
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_DELIVER_UP = 3'd0,
    ST_SEND_DOWN  = 3'd1,
    ST_DROP       = 3'd2,
    ST_STORED     = 3'd3,
    ST_FULL       = 3'd4,
    ST_INVALID    = 3'd5,
    ST_CLEARED    = 3'd6
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/static_route_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// static_route_table_top: static routing table with default gateway
// Top level: configuration registers, classifier, queue and table back end.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o) takes one word per accepted edge:
//   mode 0 adds or updates a route, mode 1 routes a packet, mode 2 clears the
//   table. Mode 3 is accepted and gives no result. Every other word gives
//   exactly one result word on the output channel (out_valid_o/out_ready_i).
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 is the
//   default gateway (zero = none), index 1 the broadcast address. Write it
//   only while the block is idle.
//   Each word passes the queue and the output register; a next-hop lookup
//   also passes the registered hop memory read in the lookup state.
//   Throughput: one word per cycle while the receiver takes results, except
//   lookups, which hold the back end in its lookup state for the read.
//   A two-word queue separates classifier and back end; when the receiver
//   stalls, the output register holds, the queue fills and in_ready_o drops.
//   Reset clears all route valid bits, the route count and the queue, sets
//   the gateway to 0 and the broadcast address to 255. Hop memory contents
//   are not reset; an entry's hop is only used while its valid bit is set.
// ----------------------------------------------------------------------------
module static_route_table_top #(
  parameter int MAX_ROUTES = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input words
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [srt_pkg::ADDR_W-1:0]  dest_address_i,
  input  wire logic [srt_pkg::ADDR_W-1:0]  hop_to_store_i,
  input  wire logic                        going_up_i,
  input  wire logic [srt_pkg::ADDR_W-1:0]  arrival_hop_i,
  // result words
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [srt_pkg::ADDR_W-1:0]       next_hop_out_o,
  output logic [srt_pkg::COUNT_W-1:0]      route_count_o,
  // configuration writes
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [srt_pkg::ADDR_W-1:0]  cfg_data_i
);
  import srt_pkg::*;

  logic [ADDR_W-1:0] gateway_q;
  logic [ADDR_W-1:0] broadcast_q;

  entry_t push_data;
  entry_t pop_data;
  logic   q_push, q_full, q_pop, q_valid;

  // config registers; every write goes straight into its register, so the port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gateway_q   <= '0;
      broadcast_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GATEWAY:   gateway_q   <= cfg_data_i;
        CFG_BROADCAST: broadcast_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // classify incoming words; broadcast compare happens here
  srt_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .dest_address_i (dest_address_i),
    .hop_to_store_i (hop_to_store_i),
    .going_up_i     (going_up_i),
    .arrival_hop_i  (arrival_hop_i),
    .broadcast_i    (broadcast_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (push_data)
  );

  srt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_data_i_o (pop_data)
  );

  // table, count and output register
  srt_back #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_data),
    .q_pop_o        (q_pop),
    .gateway_i      (gateway_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .next_hop_out_o (next_hop_out_o),
    .route_count_o  (route_count_o)
  );

endmodule
`default_nettype wire

>>> rtl/srt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srt_front: input classifier
// Accepts input words, sorts them into back-end operations and pushes them
// into the queue. The unused mode is accepted and dropped.
// ----------------------------------------------------------------------------
module srt_front (
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                mode_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] dest_address_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] hop_to_store_i,
  input  wire logic                      going_up_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] arrival_hop_i,
  input  wire logic [srt_pkg::ADDR_W-1:0] broadcast_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output srt_pkg::entry_t                q_data_o
);
  import srt_pkg::*;

  logic known_mode;
  logic deliver;

  assign in_ready_o = !q_full_i;
  assign deliver    = going_up_i &&
                      (dest_address_i == arrival_hop_i || dest_address_i == broadcast_i);
  assign known_mode = (mode_i == MODE_ADD) || (mode_i == MODE_ROUTE) ||
                      (mode_i == MODE_CLEAR);
  assign q_push_o   = in_valid_i && !q_full_i && known_mode;

  always_comb begin
    q_data_o.dest = dest_address_i;
    q_data_o.hop  = hop_to_store_i;
    case (mode_i)
      MODE_ADD: begin
        if (dest_address_i == '0 || hop_to_store_i == '0) begin
          q_data_o.op = OP_INVALID;
        end else begin
          q_data_o.op = OP_ADD;
        end
      end
      MODE_ROUTE: begin
        q_data_o.op = deliver ? OP_DELIVER : OP_LOOKUP;
      end
      default: begin
        q_data_o.op = OP_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/srt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srt_queue: short queue between classifier and back end
// Small register FIFO of operation words; lets either side stall alone.
// ----------------------------------------------------------------------------
module srt_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire srt_pkg::entry_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output srt_pkg::entry_t      pop_data_i_o
);
  import srt_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(Q_DEPTH - 1);

  entry_t           slot_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == DEPTH_C);
  assign valid_o      = (count_q != '0);
  assign pop_data_i_o = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

>>> rtl/srt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srt_back: table back end
// Executes queued operations on the 256-entry hop memory and valid bits,
// and holds the output register. Lookups pass through the S_LOOK state for the
// registered memory read.
// ----------------------------------------------------------------------------
module srt_back #(
  parameter int MAX_ROUTES = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire srt_pkg::entry_t             q_data_i,
  output logic                             q_pop_o,
  input  wire logic [srt_pkg::ADDR_W-1:0]  gateway_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [srt_pkg::ADDR_W-1:0]       next_hop_out_o,
  output logic [srt_pkg::COUNT_W-1:0]      route_count_o
);
  import srt_pkg::*;

  localparam int NUM_ENTRIES = 2 ** ADDR_W;
  localparam int LIMIT_INT   = (MAX_ROUTES > 127) ? 127 : MAX_ROUTES;
  localparam logic [COUNT_W-1:0] ROUTE_LIMIT = COUNT_W'(LIMIT_INT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic [ADDR_W-1:0]      hop_mem [NUM_ENTRIES];
  logic [ADDR_W-1:0]      rdata_q;
  logic [NUM_ENTRIES-1:0] valid_q, valid_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   state_q, state_d;
  logic                   hit_q, hit_d;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [ADDR_W-1:0]      hop_q, hop_d;
  logic [COUNT_W-1:0]     cnt_out_q, cnt_out_d;
  logic                   out_free;
  logic                   load;
  logic                   wr_en, rd_en;
  logic [ADDR_W-1:0]      sel_hop;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = q_valid_i && (state_q == S_IDLE) && out_free;
  assign sel_hop  = hit_q ? rdata_q : gateway_i;

  always_comb begin
    valid_d     = valid_q;
    count_d     = count_q;
    state_d     = state_q;
    hit_d       = hit_q;
    status_d    = status_q;
    hop_d       = hop_q;
    cnt_out_d   = cnt_out_q;
    load        = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          load  = 1'b1;
          hop_d = '0;
          case (q_data_i.op)
            OP_INVALID: begin
              status_d = ST_INVALID;
            end
            OP_ADD: begin
              if (valid_q[q_data_i.dest]) begin
                wr_en    = 1'b1;
                status_d = ST_STORED;
              end else if (count_q < ROUTE_LIMIT) begin
                wr_en                   = 1'b1;
                valid_d[q_data_i.dest]  = 1'b1;
                count_d                 = count_q + 1'b1;
                status_d                = ST_STORED;
              end else begin
                status_d = ST_FULL;
              end
            end
            OP_DELIVER: begin
              status_d = ST_DELIVER_UP;
            end
            OP_LOOKUP: begin
              // result is loaded from S_LOOK, after the registered memory read
              load    = 1'b0;
              rd_en   = 1'b1;
              hit_d   = valid_q[q_data_i.dest];
              state_d = S_LOOK;
            end
            default: begin
              valid_d  = '0;
              count_d  = '0;
              status_d = ST_CLEARED;
            end
          endcase
          cnt_out_d = count_d;
        end
      end
      default: begin
        if (out_free) begin
          load      = 1'b1;
          state_d   = S_IDLE;
          cnt_out_d = count_q;
          if (sel_hop == '0) begin
            status_d = ST_DROP;
            hop_d    = '0;
          end else begin
            status_d = ST_SEND_DOWN;
            hop_d    = sel_hop;
          end
        end
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      count_q     <= count_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (load) begin
      status_q  <= status_d;
      hop_q     <= hop_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  // hop memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hop_mem[q_data_i.dest] <= q_data_i.hop;
    end
    if (rd_en) begin
      rdata_q <= hop_mem[q_data_i.dest];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign next_hop_out_o = hop_q;
  assign route_count_o  = cnt_out_q;

`ifndef ASSERT_OFF
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ROUTE_LIMIT)
    else $error("route count above limit");
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("route count does not match valid bits");
  a_send_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_SEND_DOWN) |-> (hop_q != '0))
    else $error("send down with zero hop");
  a_look_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> !q_pop_o)
    else $error("pop during lookup");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for static_route_table_top
// Sends add, route and clear words with random gaps on both channels. A
// behavioral copy of the route table predicts every result word that no typed row gives, and each
// result is compared in order. The gateway and broadcast registers change
// between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int         ROUTE_LIMIT    = 64;
  localparam int         SETTLE_CYCLES  = 4;     // slack for a resultless word to drain
  localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int         PHASE_WORDS    = 150;
  localparam int         MAX_REPORTS    = 10;
  localparam logic [1:0] MODE_NONE      = 2'd3;  // accepted, gives no result

  typedef struct {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
    logic              up;
    logic [ADDR_W-1:0] arrival;
  } word_t;

  typedef struct {
    status_e            status;
    logic [ADDR_W-1:0]  fwd_hop;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct {
    word_t   w;
    bit      fixed;  // use the typed result instead of the prediction
    result_t r;
  } stim_row_t;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i         = MODE_ADD;
  logic [ADDR_W-1:0]  dest_address_i = '0;
  logic [ADDR_W-1:0]  hop_to_store_i = '0;
  logic               going_up_i     = 1'b0;
  logic [ADDR_W-1:0]  arrival_hop_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [2:0]         status_o;
  logic [ADDR_W-1:0]  next_hop_out_o;
  logic [COUNT_W-1:0] route_count_o;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i    = CFG_GATEWAY;
  logic [ADDR_W-1:0]  cfg_data_i     = '0;

  // shadow of the route table, kept in step with accepted words
  logic [ADDR_W-1:0] hop_mem [256];
  bit                valid_mem [256];
  int unsigned       n_routes    = 0;
  logic [ADDR_W-1:0] gateway_reg = 8'd0;
  logic [ADDR_W-1:0] bcast_reg   = 8'd255;

  result_t           pending_results [$];
  stim_row_t         stim_rows [$];
  logic [ADDR_W-1:0] known_dests [$];  // recently stored destinations, for hits

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  int peak_routes     = 0;
  int status_seen [8];

  static_route_table_top #(
    .MAX_ROUTES(ROUTE_LIMIT)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .dest_address_i(dest_address_i),
    .hop_to_store_i(hop_to_store_i),
    .going_up_i    (going_up_i),
    .arrival_hop_i (arrival_hop_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .next_hop_out_o(next_hop_out_o),
    .route_count_o (route_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Next-hop decision and table update for one accepted word. has_res is
  // low for the unused mode, which leaves everything untouched.
  task automatic predict_route(input word_t w, output bit has_res, output result_t r);
    logic [ADDR_W-1:0] nh;
    int unsigned       lim;
    lim       = (ROUTE_LIMIT > 127) ? 127 : ROUTE_LIMIT;
    has_res   = 1'b1;
    r.status  = ST_CLEARED;
    r.fwd_hop = '0;
    case (w.mode)
      MODE_ADD: begin
        if (w.dest == '0 || w.hop == '0) begin
          r.status = ST_INVALID;
        end else if (valid_mem[w.dest]) begin
          // existing destination: overwrite even when the table is full
          hop_mem[w.dest] = w.hop;
          r.status        = ST_STORED;
        end else if (n_routes < lim) begin
          hop_mem[w.dest]   = w.hop;
          valid_mem[w.dest] = 1'b1;
          n_routes++;
          r.status = ST_STORED;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_ROUTE: begin
        if (w.up && (w.dest == w.arrival || w.dest == bcast_reg)) begin
          r.status = ST_DELIVER_UP;
        end else begin
          // table entry first, then the gateway; zero means nowhere to go
          nh = valid_mem[w.dest] ? hop_mem[w.dest] : gateway_reg;
          if (nh == '0) begin
            r.status = ST_DROP;
          end else begin
            r.status  = ST_SEND_DOWN;
            r.fwd_hop = nh;
          end
        end
      end
      MODE_CLEAR: begin
        // only valid bits go; stale hops stay but are never read
        foreach (valid_mem[i]) valid_mem[i] = 1'b0;
        n_routes = 0;
        r.status = ST_CLEARED;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
    r.count = COUNT_W'(n_routes);
  endtask

  // Present one word, hold it until accepted, then queue its expected result.
  // Valid is only lowered for a gap, so it never drops and rises in one step.
  task automatic send_word(input word_t w, input bit use_typed, input result_t typed);
    bit      has_res;
    result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= w.mode;
    dest_address_i <= w.dest;
    hop_to_store_i <= w.hop;
    going_up_i     <= w.up;
    arrival_hop_i  <= w.arrival;
    do @(posedge clk_i); while (!in_ready_o);
    predict_route(w, has_res, r);
    if (has_res) begin
      if (use_typed) pending_results.push_back(typed);
      else pending_results.push_back(r);
    end
    if (w.mode != MODE_NONE) words_sent++;
    if (w.mode == MODE_ADD && r.status == ST_STORED) begin
      known_dests.push_back(w.dest);
      if (known_dests.size() > 64) void'(known_dests.pop_front());
    end
  endtask

  task automatic add_row(input logic [1:0] m, input logic [ADDR_W-1:0] d, h,
                         input logic u, input logic [ADDR_W-1:0] a, input bit fx,
                         input status_e st, input logic [ADDR_W-1:0] nh,
                         input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.w.mode    = m;
    row.w.dest    = d;
    row.w.hop     = h;
    row.w.up      = u;
    row.w.arrival = a;
    row.fixed     = fx;
    row.r.status  = st;
    row.r.fwd_hop = nh;
    row.r.count   = cnt;
    stim_rows.push_back(row);
  endtask

  // Random word. Fill bias means mostly adds to fresh destinations, so the
  // table runs into its limit; otherwise routes dominate and aim at stored
  // destinations, the broadcast address and matching arrival hops.
  function automatic word_t rand_word(input bit fill_bias);
    word_t w;
    int    pick;
    w.dest    = ADDR_W'($urandom_range(0, 255));
    w.hop     = ADDR_W'($urandom_range(0, 255));
    w.up      = 1'($urandom_range(0, 1));
    w.arrival = ADDR_W'($urandom_range(0, 255));
    pick      = $urandom_range(0, 99);
    if (fill_bias) w.mode = (pick < 85) ? MODE_ADD : MODE_ROUTE;
    else if (pick < 30) w.mode = MODE_ADD;
    else if (pick < 90) w.mode = MODE_ROUTE;
    else if (pick < 94) w.mode = MODE_CLEAR;
    else w.mode = MODE_NONE;
    case (w.mode)
      MODE_ADD: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          w.dest = '0;
        end else if (pick == 1) begin
          w.hop = '0;
        end else begin
          w.dest = ADDR_W'($urandom_range(1, 255));
          w.hop  = ADDR_W'($urandom_range(1, 255));
          if (!fill_bias && pick < 5 && known_dests.size() > 0)
            w.dest = known_dests[$urandom_range(0, known_dests.size() - 1)];
        end
      end
      MODE_ROUTE: begin
        pick = $urandom_range(0, 7);
        if (pick == 0) w.dest = bcast_reg;
        else if (pick < 5 && known_dests.size() > 0)
          w.dest = known_dests[$urandom_range(0, known_dests.size() - 1)];
        if ($urandom_range(0, 3) == 0) w.arrival = w.dest;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Wait out every expected word, plus the slack a resultless word may need.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random phase: registers are rewritten while idle, then episodes of
  // fill-heavy or mixed traffic run until the phase word count is reached.
  task automatic run_phase(input int snd_pct, input int rcv_pct,
                           input logic [ADDR_W-1:0] gw, input logic [ADDR_W-1:0] bc,
                           input bit force_fill);
    word_t   w;
    result_t unused_r;
    int      done;
    int      len;
    bit      fill;
    bit      first;
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GATEWAY;
    cfg_data_i  <= gw;
    do @(posedge clk_i); while (!cfg_ready_o);
    gateway_reg = gw;
    cfg_index_i <= CFG_BROADCAST;
    cfg_data_i  <= bc;
    do @(posedge clk_i); while (!cfg_ready_o);
    bcast_reg = bc;
    cfg_valid_i <= 1'b0;

    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    unused_r.status  = ST_DROP;
    unused_r.fwd_hop = '0;
    unused_r.count   = '0;
    done  = 0;
    first = 1'b1;
    while (done < PHASE_WORDS) begin
      fill = (first && force_fill) || ($urandom_range(0, 2) == 0);
      len  = fill ? $urandom_range(110, 130) : $urandom_range(10, 40);
      first = 1'b0;
      if (fill) begin
        // start from an empty table so the limit is reached inside the episode
        w      = rand_word(1'b0);
        w.mode = MODE_CLEAR;
        send_word(w, 1'b0, unused_r);
        done++;
      end
      for (int k = 0; k < len && done < PHASE_WORDS; k++) begin
        w = rand_word(fill);
        send_word(w, 1'b0, unused_r);
        if (w.mode != MODE_NONE) done++;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Random backpressure on the result channel.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result word status %0d hop %0d count %0d",
                   $realtime, status_o, next_hop_out_o, route_count_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (int'(want.count) > peak_routes) peak_routes = want.count;
        if (status_o !== want.status || next_hop_out_o !== want.fwd_hop ||
            route_count_o !== want.count) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch (exp/got) status %0d/%0d hop %0d/%0d count %0d/%0d",
                     $realtime, want.status, status_o, want.fwd_hop, next_hop_out_o,
                     want.count, route_count_o);
        end
      end
    end
  end

  // Watchdog: a long stretch without any handshake means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("static_route_table_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed rows. Registers are at reset values: no gateway, broadcast 255.
    // Typed rows are the obvious ones; the rest go through the predictor.
    //      mode        dest   hop    up    arr    fx    status         hop    count
    add_row(MODE_ROUTE, 8'h55, 8'h00, 1'b0, 8'h00, 1'b1, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1, ST_DELIVER_UP, 8'h00, 7'd0);
    // zero address or zero hop is refused
    add_row(MODE_ADD,   8'h00, 8'h05, 1'b0, 8'h00, 1'b1, ST_INVALID,    8'h00, 7'd0);
    add_row(MODE_ADD,   8'h07, 8'h00, 1'b0, 8'h00, 1'b1, ST_INVALID,    8'h00, 7'd0);
    add_row(MODE_ADD,   8'h00, 8'h00, 1'b0, 8'h00, 1'b1, ST_INVALID,    8'h00, 7'd0);
    add_row(MODE_ADD,   8'h01, 8'hFF, 1'b0, 8'h00, 1'b1, ST_STORED,     8'h00, 7'd1);
    add_row(MODE_ADD,   8'hFF, 8'h01, 1'b0, 8'h00, 1'b1, ST_STORED,     8'h00, 7'd2);
    add_row(MODE_ADD,   8'h80, 8'hAA, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    // overwrite of an existing destination keeps the count
    add_row(MODE_ADD,   8'h01, 8'h7F, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    // broadcast address going down is routed normally
    add_row(MODE_ROUTE, 8'hFF, 8'h00, 1'b0, 8'hFF, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h80, 8'h00, 1'b1, 8'h80, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h80, 8'h00, 1'b1, 8'h7F, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h42, 8'h00, 1'b1, 8'h41, 1'b0, ST_DROP,       8'h00, 7'd0);
    // unused mode, all fields high: no result
    add_row(MODE_NONE,  8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0, ST_DROP,       8'h00, 7'd0);
    // fields that do not belong to the operation are ignored
    add_row(MODE_ADD,   8'h42, 8'h24, 1'b1, 8'hFF, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h42, 8'hFF, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1, ST_CLEARED,    8'h00, 7'd0);
    // stale hop after clear must not be used
    add_row(MODE_ROUTE, 8'h01, 8'h00, 1'b0, 8'h00, 1'b1, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ADD,   8'h01, 8'h33, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_ROUTE, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0, ST_DROP,       8'h00, 7'd0);
    add_row(MODE_CLEAR, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, ST_CLEARED,    8'h00, 7'd0);

    send_idle_pct = 37;
    recv_idle_pct = 78;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) send_word(stim_rows[i].w, stim_rows[i].fixed, stim_rows[i].r);
    in_valid_i <= 1'b0;

    // gap profiles: slow receiver, then slow sender, then full rate
    run_phase(37, 78, 8'hFF, 8'h00, 1'b1);
    run_phase(78, 37, ADDR_W'($urandom_range(1, 254)), ADDR_W'($urandom_range(1, 254)),
              1'b0);
    run_phase(0, 0, 8'h00, 8'h80, 1'b0);

    settle();
    $display("Covered %0d words over directed rows and three gap profiles; %0d checked",
             words_sent, results_checked);
    $display("Outcomes up/down/drop/stored/full/invalid/cleared %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[ST_DELIVER_UP], status_seen[ST_SEND_DOWN], status_seen[ST_DROP],
             status_seen[ST_STORED], status_seen[ST_FULL], status_seen[ST_INVALID],
             status_seen[ST_CLEARED]);
    if (fail_count == 0) begin
      $display("static_route_table_top verification clean");
    end else begin
      $display("static_route_table_top verification failed");
    end
    $finish;
  end

endmodule
